// ===== hw/rtl/rcci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcci_pkg
// Types, widths and helpers for the ray / cylinder end-cap intersector.
// ----------------------------------------------------------------------------
package rcci_pkg;

  localparam int FracBits  = 16;
  localparam int DW        = 32;
  localparam int TW        = 31;
  localparam int MinW      = 16;
  localparam int IntBits   = TW - FracBits;
  localparam int PdW       = 2 * DW - FracBits;
  localparam int TcW       = DW + 1;
  localparam int PtW       = DW + TcW - FracBits;
  localparam int NW        = PtW + 2;
  localparam int RemW      = NW + FracBits;
  localparam int DivStages = TW + 1;
  localparam int OffW      = PdW + 1;
  localparam int SqW       = 2 * TW;
  localparam int Dist2W    = SqW + 2;
  localparam int FrontLat  = 4;
  localparam int RadLat    = 4;
  localparam int Latency   = FrontLat + DivStages + RadLat + 1;

  localparam logic [TW-1:0] TMax = '1;

  typedef enum logic [2:0] {
    CfgAxisX  = 3'd0,
    CfgAxisY  = 3'd1,
    CfgAxisZ  = 3'd2,
    CfgRadius = 3'd3,
    CfgMinDist = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DW-1:0] origin_x;
    logic signed [DW-1:0] origin_y;
    logic signed [DW-1:0] origin_z;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic signed [DW-1:0] top_cx;
    logic signed [DW-1:0] top_cy;
    logic signed [DW-1:0] top_cz;
    logic signed [DW-1:0] bot_cx;
    logic signed [DW-1:0] bot_cy;
    logic signed [DW-1:0] bot_cz;
  } in_t;

  typedef struct packed {
    logic          hit;
    logic [TW-1:0] hit_distance;
    logic          hit_top;
  } out_t;

  typedef struct packed {
    logic                  neg;
    logic signed [TcW-1:0] tc_x;
    logic signed [TcW-1:0] tc_y;
    logic signed [TcW-1:0] tc_z;
  } cap_side_t;

  typedef struct packed {
    logic                 para;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    cap_side_t            top;
    cap_side_t            bot;
  } side_t;

  typedef struct packed {
    side_t         side;
    logic [NW-1:0] m;
    logic [NW-1:0] n_top;
    logic [NW-1:0] n_bot;
  } front_t;

  function automatic logic [NW-1:0] mag(logic signed [NW-1:0] v);
    logic signed [NW-1:0] nv;
    nv = -v;
    return v[NW-1] ? nv : v;
  endfunction

endpackage

// ===== hw/rtl/rcci_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcci_front
// Four stages: cap offsets, dot-product terms, sums, magnitudes and signs.
// ----------------------------------------------------------------------------
module rcci_front import rcci_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  in_t                  data_i,
  input  logic signed [DW-1:0] axis_x_i,
  input  logic signed [DW-1:0] axis_y_i,
  input  logic signed [DW-1:0] axis_z_i,
  output front_t               front_o
);

  logic signed [DW-1:0]  ax [3];
  logic signed [DW-1:0]  dir0 [3];

  logic signed [DW-1:0]  dir1_q [3];
  logic signed [TcW-1:0] tct1_q [3];
  logic signed [TcW-1:0] tcb1_q [3];

  logic signed [DW-1:0]  dir2_q [3];
  logic signed [TcW-1:0] tct2_q [3];
  logic signed [TcW-1:0] tcb2_q [3];
  logic signed [PdW-1:0] pd2_q [3];
  logic signed [PtW-1:0] pt2_q [3];
  logic signed [PtW-1:0] pb2_q [3];

  logic signed [DW-1:0]  dir3_q [3];
  logic signed [TcW-1:0] tct3_q [3];
  logic signed [TcW-1:0] tcb3_q [3];
  logic signed [NW-1:0]  d0_q, dt_q, db_q;

  front_t front_q;

  assign ax[0]   = axis_x_i;
  assign ax[1]   = axis_y_i;
  assign ax[2]   = axis_z_i;
  assign dir0[0] = data_i.dir_x;
  assign dir0[1] = data_i.dir_y;
  assign dir0[2] = data_i.dir_z;

  // stage 1: centre minus origin
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir1_q    <= dir0;
      tct1_q[0] <= TcW'(data_i.top_cx) - TcW'(data_i.origin_x);
      tct1_q[1] <= TcW'(data_i.top_cy) - TcW'(data_i.origin_y);
      tct1_q[2] <= TcW'(data_i.top_cz) - TcW'(data_i.origin_z);
      tcb1_q[0] <= TcW'(data_i.bot_cx) - TcW'(data_i.origin_x);
      tcb1_q[1] <= TcW'(data_i.bot_cy) - TcW'(data_i.origin_y);
      tcb1_q[2] <= TcW'(data_i.bot_cz) - TcW'(data_i.origin_z);
    end
  end

  // stage 2: products, floored to the fixed-point grid
  logic signed [2*DW-1:0]    pd_d [3];
  logic signed [DW+TcW-1:0]  pt_d [3];
  logic signed [DW+TcW-1:0]  pb_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd_d[i] = (2*DW)'(ax[i]) * (2*DW)'(dir1_q[i]);
      pt_d[i] = (DW+TcW)'(ax[i]) * (DW+TcW)'(tct1_q[i]);
      pb_d[i] = (DW+TcW)'(ax[i]) * (DW+TcW)'(tcb1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir2_q <= dir1_q;
      tct2_q <= tct1_q;
      tcb2_q <= tcb1_q;
      for (int i = 0; i < 3; i++) begin
        pd2_q[i] <= pd_d[i][2*DW-1:FracBits];
        pt2_q[i] <= pt_d[i][DW+TcW-1:FracBits];
        pb2_q[i] <= pb_d[i][DW+TcW-1:FracBits];
      end
    end
  end

  // stage 3: sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir3_q <= dir2_q;
      tct3_q <= tct2_q;
      tcb3_q <= tcb2_q;
      d0_q   <= NW'(pd2_q[0]) + NW'(pd2_q[1]) + NW'(pd2_q[2]);
      dt_q   <= NW'(pt2_q[0]) + NW'(pt2_q[1]) + NW'(pt2_q[2]);
      db_q   <= NW'(pb2_q[0]) + NW'(pb2_q[1]) + NW'(pb2_q[2]);
    end
  end

  // stage 4: magnitudes, quotient signs, parallel flag
  front_t front_d;

  always_comb begin
    front_d.side.para     = (d0_q == '0);
    front_d.side.dir_x    = dir3_q[0];
    front_d.side.dir_y    = dir3_q[1];
    front_d.side.dir_z    = dir3_q[2];
    front_d.side.top.neg  = dt_q[NW-1] ^ d0_q[NW-1];
    front_d.side.top.tc_x = tct3_q[0];
    front_d.side.top.tc_y = tct3_q[1];
    front_d.side.top.tc_z = tct3_q[2];
    front_d.side.bot.neg  = db_q[NW-1] ^ d0_q[NW-1];
    front_d.side.bot.tc_x = tcb3_q[0];
    front_d.side.bot.tc_y = tcb3_q[1];
    front_d.side.bot.tc_z = tcb3_q[2];
    front_d.m             = mag(d0_q);
    front_d.n_top         = mag(dt_q);
    front_d.n_bot         = mag(db_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== hw/rtl/rcci_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcci_div
// Pipelined restoring divider: t = n * 2^F / m, one quotient bit per stage,
// saturating when the integer part overflows.
// ----------------------------------------------------------------------------
module rcci_div import rcci_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [NW-1:0] m_i,
  output logic [TW-1:0] q_o
);

  logic [RemW-1:0] rem_q [TW+1];
  logic [NW-1:0]   m_q   [TW+1];
  logic [TW-1:0]   quo_q [TW+1];
  logic            sat_q [TW+1];

  logic [RemW-1:0] rem_d [TW+1];
  logic [TW-1:0]   quo_d [TW+1];

  always_comb begin
    rem_d[0] = {n_i, FracBits'(0)};
    quo_d[0] = '0;
    for (int j = 0; j < TW; j++) begin
      logic [RemW+TW-1:0] mk;
      mk = (RemW+TW)'(m_q[j]) << (TW - 1 - j);
      if ((RemW+TW)'(rem_q[j]) >= mk) begin
        rem_d[j+1] = rem_q[j] - mk[RemW-1:0];
        quo_d[j+1] = quo_q[j] | (TW'(1) << (TW - 1 - j));
      end else begin
        rem_d[j+1] = rem_q[j];
        quo_d[j+1] = quo_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      m_q[0]   <= m_i;
      sat_q[0] <= {IntBits'(0), n_i} >= {m_i, IntBits'(0)};
      for (int j = 1; j <= TW; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        m_q[j]   <= m_q[j-1];
        sat_q[j] <= sat_q[j-1];
      end
    end
  end

  assign q_o = sat_q[TW] ? TMax : quo_q[TW];

endmodule

// ===== hw/rtl/rcci_rad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcci_rad
// Per-cap acceptance: sign and minimum-distance checks, then the squared
// radius test on the hit point. Four stages.
// ----------------------------------------------------------------------------
module rcci_rad import rcci_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [TW-1:0]         q_i,
  input  logic                  para_i,
  input  logic signed [DW-1:0]  dir_x_i,
  input  logic signed [DW-1:0]  dir_y_i,
  input  logic signed [DW-1:0]  dir_z_i,
  input  cap_side_t             cap_i,
  input  logic [TW-1:0]         radius_i,
  input  logic [MinW-1:0]       min_i,
  output logic                  hit_o,
  output logic [TW-1:0]         t_o
);

  logic signed [DW-1:0]   dir [3];
  logic signed [TcW-1:0]  tc0 [3];
  logic signed [2*DW-1:0] p_d [3];

  logic signed [PdW-1:0]  p1_q [3];
  logic signed [TcW-1:0]  tc1_q [3];
  logic [SqW-1:0]         r2_1_q, r2_2_q, r2_3_q;
  logic [TW-1:0]          t1_q, t2_q, t3_q, t4_q;
  logic                   miss1_q, miss2_q, miss3_q, hit4_q;
  logic [TW-1:0]          mo2_q [3];
  logic [SqW-1:0]         sq3_q [3];

  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;
  assign tc0[0] = cap_i.tc_x;
  assign tc0[1] = cap_i.tc_y;
  assign tc0[2] = cap_i.tc_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_d[i] = (2*DW)'(dir[i]) * (2*DW)'($signed({1'b0, q_i}));
    end
  end

  // stage 1: dir * t
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= p_d[i][2*DW-1:FracBits];
      end
      tc1_q   <= tc0;
      t1_q    <= q_i;
      r2_1_q  <= SqW'(radius_i) * SqW'(radius_i);
      miss1_q <= para_i || (cap_i.neg && (q_i != '0)) || (q_i < TW'(min_i));
    end
  end

  // stage 2: offset magnitudes
  logic signed [OffW-1:0] off_d [3];
  logic [OffW-1:0]        mo_d [3];
  logic                   big_d;

  always_comb begin
    big_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      off_d[i] = OffW'(p1_q[i]) - OffW'(tc1_q[i]);
      mo_d[i]  = off_d[i][OffW-1] ? OffW'(-off_d[i]) : OffW'(off_d[i]);
      big_d    = big_d | (|mo_d[i][OffW-1:TW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mo2_q[i] <= mo_d[i][TW-1:0];
      end
      t2_q    <= t1_q;
      r2_2_q  <= r2_1_q;
      miss2_q <= miss1_q || big_d;
    end
  end

  // stage 3: squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= SqW'(mo2_q[i]) * SqW'(mo2_q[i]);
      end
      t3_q    <= t2_q;
      r2_3_q  <= r2_2_q;
      miss3_q <= miss2_q;
    end
  end

  // stage 4: squared distance against squared radius
  logic [Dist2W-1:0] dist2_d;

  assign dist2_d = Dist2W'(sq3_q[0]) + Dist2W'(sq3_q[1]) + Dist2W'(sq3_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_q   <= t3_q;
      hit4_q <= !miss3_q && (dist2_d < Dist2W'(r2_3_q));
    end
  end

  assign hit_o = hit4_q;
  assign t_o   = t4_q;

endmodule

// ===== hw/rtl/ray_cylinder_cap_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_cylinder_cap_intersect
// Ray against the two end caps of a cylinder, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Pipeline: 4 front stages, 32 divider stages, 4 radius-test stages and 1 output
// register between input beat and output beat.
// Throughput: one ray per cycle; the whole pipeline holds while the output
// beat is stalled.
// Reset clears all stage valid bits and loads the default configuration.
module ray_cylinder_cap_intersect import rcci_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic signed [DW-1:0] axis_x_q, axis_y_q, axis_z_q;
  logic [TW-1:0]        radius_q;
  logic [MinW-1:0]      min_q;

  logic                 en;
  logic [Latency-1:0]   v_q;
  front_t               front;
  side_t                side_q [DivStages];
  logic [TW-1:0]        qt, qb, tt, tb;
  logic                 ht, hb;
  out_t                 out_d, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= '0;
      axis_y_q <= '0;
      axis_z_q <= DW'(1) <<< FracBits;
      radius_q <= TW'(1) << FracBits;
      min_q    <= MinW'(7);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgAxisX:   axis_x_q <= cfg_data_i;
        CfgAxisY:   axis_y_q <= cfg_data_i;
        CfgAxisZ:   axis_z_q <= cfg_data_i;
        CfgRadius:  radius_q <= cfg_data_i[TW-1:0];
        CfgMinDist: min_q    <= cfg_data_i[MinW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !v_q[Latency-1] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Latency-2:0], in_valid_i};
    end
  end

  rcci_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .data_i   (in_data_i),
    .axis_x_i (axis_x_q),
    .axis_y_i (axis_y_q),
    .axis_z_i (axis_z_q),
    .front_o  (front)
  );

  rcci_div u_div_top (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (front.n_top),
    .m_i   (front.m),
    .q_o   (qt)
  );

  rcci_div u_div_bot (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (front.n_bot),
    .m_i   (front.m),
    .q_o   (qb)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= front.side;
      for (int j = 1; j < DivStages; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  rcci_rad u_rad_top (
    .clk_i    (clk_i),
    .en_i     (en),
    .q_i      (qt),
    .para_i   (side_q[DivStages-1].para),
    .dir_x_i  (side_q[DivStages-1].dir_x),
    .dir_y_i  (side_q[DivStages-1].dir_y),
    .dir_z_i  (side_q[DivStages-1].dir_z),
    .cap_i    (side_q[DivStages-1].top),
    .radius_i (radius_q),
    .min_i    (min_q),
    .hit_o    (ht),
    .t_o      (tt)
  );

  rcci_rad u_rad_bot (
    .clk_i    (clk_i),
    .en_i     (en),
    .q_i      (qb),
    .para_i   (side_q[DivStages-1].para),
    .dir_x_i  (side_q[DivStages-1].dir_x),
    .dir_y_i  (side_q[DivStages-1].dir_y),
    .dir_z_i  (side_q[DivStages-1].dir_z),
    .cap_i    (side_q[DivStages-1].bot),
    .radius_i (radius_q),
    .min_i    (min_q),
    .hit_o    (hb),
    .t_o      (tb)
  );

  // nearer cap; bottom wins a tie
  always_comb begin
    out_d = '0;
    priority if (ht && (!hb || (tt < tb))) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = tt;
      out_d.hit_top      = 1'b1;
    end else if (hb) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = tb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[Latency-1];
  assign out_data_o  = out_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      (out_data_o.hit_distance == '0) && !out_data_o.hit_top)
    else $error("miss beat carries a distance or cap flag");

  a_hit_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_distance >= TW'(min_q))
    else $error("hit closer than the minimum distance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved while held");

endmodule
